// ----- rtl/core/sli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes for the sorted list block.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [POS_W-1:0]    count;
   } rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic capture;
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

// ----- rtl/core/sli_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface sli_chan_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/sli_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted list: holds an entry, compares it with the key
// and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module sli_cell
   import sli_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic signed [VALUE_W-1:0] key,
   input  logic [CW-1:0]             count,
   input  logic                      left_lt,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic signed [VALUE_W-1:0] right_entry,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      lt,
   output logic                      at_pos,
   output logic                      hit
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      lt_ff, eq_ff;
   logic                      occupied;

   assign occupied = count > CW'(IDX);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !lt_ff) begin
         entry_in = left_lt ? key : left_entry;
      end else if (cmd.remove && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.capture) begin
         lt_ff <= occupied && (entry_ff < key);
         eq_ff <= occupied && (entry_ff == key);
      end
   end

   assign entry  = entry_ff;
   assign lt     = lt_ff;
   assign at_pos = !lt_ff && left_lt;
   assign hit    = at_pos && eq_ff;

endmodule

// ----- rtl/core/sorted_list_insert_remove_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top
// Ascending list of signed values held in a row of cells; insert, remove
// and find operations, one result word per request word.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | handshake
//  req     | in  | opcode, value                | valid / ready
//  rsp     | out | status, position, count      | valid / ready
//
//  Each request passes through accept, a compare state in which every cell
//  registers its less/equal flags, and an update state in which the cells
//  shift for an insert or remove and the result word is loaded.
//  The next request is accepted once the update state is done.
//  A stalled rsp holds the update state until the output register frees.
//  Synchronous reset empties the list; entry contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top
   import sli_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   sli_chan_if.sink   req,
   sli_chan_if.source rsp
);

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_UPD  = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [OPCODE_W-1:0]       op_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0]       lt_w, at_pos_w, hit_w;
   logic [CW-1:0]             pos_w;
   logic                      slot_free, accept, update, full, found;
   logic [STATUS_W-1:0]       status_w;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign update    = (state_ff == S_UPD) && slot_free;
   assign full      = count_ff == CW'(CAPACITY);
   assign found     = |hit_w;

   always_comb begin
      pos_w = lt_w[CAPACITY-1] ? CW'(CAPACITY) : '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (at_pos_w[i]) begin
            pos_w = pos_w | CW'(i);
         end
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == S_CMP);
      count_in    = count_ff;
      status_w    = ST_DONE;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_w = ST_FULL;
            end else begin
               cmd.insert = update;
               count_in   = count_ff + CW'(1);
            end
         end
         OP_REMOVE: begin
            if (count_ff == '0) begin
               status_w = ST_EMPTY;
            end else if (!found) begin
               status_w = ST_NOT_FOUND;
            end else begin
               cmd.remove = update;
               count_in   = count_ff - CW'(1);
            end
         end
         default: begin
            status_w = ST_DONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      if (update) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = status_w;
         rsp_data_in.position = POS_W'(pos_w);
         rsp_data_in.count    = POS_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (update) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         op_ff  <= req.data.opcode;
         key_ff <= req.data.value;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      left_lt;
      logic signed [VALUE_W-1:0] left_entry, right_entry;

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = key_ff;
      end else begin : g_mid
         assign left_lt    = lt_w[i-1];
         assign left_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_inner
         assign right_entry = entry_w[i+1];
      end

      sli_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .key         (key_ff),
         .count       (count_ff),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .lt          (lt_w[i]),
         .at_pos      (at_pos_w[i]),
         .hit         (hit_w[i])
      );
   end

endmodule

// ----- rtl/core/sli_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_checker
// Port-level checks for the sorted list block, bound to its top level.
// ----------------------------------------------------------------------------
module sli_checker
   import sli_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [POS_W-1:0]    rsp_position,
   input logic [POS_W-1:0]    rsp_count
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_count))
      else $error("rsp word changed while stalled");

   // one word in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == POS_W'(CAPACITY))
      else $error("full status with count below capacity");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && rsp_position == '0)
      else $error("empty status with nonzero position or count");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && CAPACITY < 32 |-> rsp_position <= rsp_count)
      else $error("position beyond count");

endmodule

bind sorted_list_insert_remove_top sli_checker #(
   .CAPACITY (CAPACITY)
) u_sli_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_status   (rsp.data.status),
   .rsp_position (rsp.data.position),
   .rsp_count    (rsp.data.count)
);

// ----- bench/sorted_list_insert_remove_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top_tb
// Self-checking bench for the sorted list block. Directed words cover the
// empty list, the value extremes, duplicates, misses and a full list; random
// grow and shrink phases follow. Every result word is checked against a
// list model kept in the bench.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top_tb;
   import sli_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_WORDS = 1100;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [OPCODE_W-1:0]       OP_RESERVED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VAL_MIN     = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX     = 32'sh7fff_ffff;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sli_chan_if #(.PAYLOAD_TYPE(req_type)) req_if ();
   sli_chan_if #(.PAYLOAD_TYPE(rsp_type)) rsp_if ();

   sorted_list_insert_remove_top #(.CAPACITY(LIST_DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   logic signed [VALUE_W-1:0] list_model[$];
   rsp_type                   expected_rsp[$];
   int                        fail_count  = 0;
   int                        cycle_count = 0;
   int                        word_count  = 0;
   int                        full_count  = 0;
   int                        empty_count = 0;
   int                        miss_count  = 0;
   bit                        quiet       = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // list model: returns the result word and updates the held entries
   function automatic rsp_type predict_list_op(input req_type w);
      rsp_type                   r;
      int                        pos;
      logic signed [VALUE_W-1:0] key;
      key = w.value;
      pos = 0;
      while (pos < list_model.size() && list_model[pos] < key) pos++;
      r.status = ST_DONE;
      case (w.opcode)
         OP_INSERT: begin
            if (list_model.size() >= LIST_DEPTH) r.status = ST_FULL;
            else list_model.insert(pos, key);
         end
         OP_REMOVE: begin
            if (list_model.size() == 0) begin
               r.status = ST_EMPTY;
               pos = 0;
            end else if (pos >= list_model.size() || list_model[pos] != key) begin
               r.status = ST_NOT_FOUND;
            end else begin
               list_model.delete(pos);
            end
         end
         default: ;
      endcase
      r.position = pos[POS_W-1:0];
      r.count    = POS_W'(list_model.size());
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_key(input int held_pct);
      int r;
      int near;
      r = $urandom_range(99);
      if (list_model.size() > 0 && r < held_pct)
         return list_model[$urandom_range(list_model.size() - 1)];
      r = $urandom_range(99);
      if (r < 50) begin
         near = $urandom_range(16);
         return near - 8;
      end
      if (r < 80) return $urandom;
      case ($urandom_range(3))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return VAL_MIN + 1;
         default: return VAL_MAX - 1;
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [OPCODE_W-1:0] op,
                            input logic signed [VALUE_W-1:0] val);
      int      gap;
      req_type w;
      gap = pick_gap();
      w.opcode = op;
      w.value  = val;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.data  <= w;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      @(negedge clock);
   endtask

   task automatic test_empty_list();
      send_word(OP_FIND, 32'sd0);
      send_word(OP_REMOVE, 32'sd5);
      send_word(OP_RESERVED, VAL_MAX);
   endtask

   task automatic test_extremes();
      send_word(OP_INSERT, VAL_MAX);
      send_word(OP_INSERT, VAL_MIN);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_FIND, 32'sd0);
      send_word(OP_REMOVE, 32'sd5);
      send_word(OP_REMOVE, -32'sd1);
      send_word(OP_REMOVE, VAL_MAX);
   endtask

   task automatic test_fill_to_full();
      for (int i = 0; i < LIST_DEPTH - 2; i++) send_word(OP_INSERT, i * 1000 - 7000);
      send_word(OP_INSERT, VAL_MAX);
      send_word(OP_INSERT, VAL_MIN);
      send_word(OP_FIND, VAL_MAX);
   endtask

   task automatic test_random_phases();
      int                  sent;
      int                  phase_len;
      int                  r;
      bit                  grow;
      logic [OPCODE_W-1:0] op;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         grow      = $urandom_range(1);
         quiet     = ($urandom_range(3) == 0);
         phase_len = $urandom_range(20, 60);
         repeat (phase_len) begin
            r = $urandom_range(99);
            if (r < 5) op = OP_RESERVED;
            else if (r < 20) op = OP_FIND;
            else if (r < (grow ? 76 : 44)) op = OP_INSERT;
            else op = OP_REMOVE;
            case (op)
               OP_REMOVE: send_word(op, pick_key(75));
               OP_INSERT: send_word(op, pick_key(25));
               default:   send_word(op, pick_key(40));
            endcase
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   // result side stalls
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (!reset && req_if.valid && req_if.ready) begin
         want = predict_list_op(req_if.data);
         expected_rsp.push_back(want);
         word_count++;
         case (want.status)
            ST_FULL:      full_count++;
            ST_EMPTY:     empty_count++;
            ST_NOT_FOUND: miss_count++;
            default: ;
         endcase
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_rsp.size() == 0) begin
            $error("result word with no request pending");
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               fail_count++;
            end
            if (got.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, got.position);
               fail_count++;
            end
            if (got.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, got.count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout, %0d results outstanding", expected_rsp.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      reset        = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_list();
      test_extremes();
      test_fill_to_full();
      test_random_phases();
      req_if.valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words through the list, %0d cycles", word_count, cycle_count);
      $display("full refusals %0d, empty removes %0d, missed removes %0d",
               full_count, empty_count, miss_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
